[rtl/core/atcd_pkg.sv]
package atcd_pkg;

  // Field widths fixed by the interface.
  localparam int SampleW  = 32;
  localparam int CountW   = 32;
  localparam int AlphaW   = 17;
  localparam int GainW    = 16;
  localparam int WarmupW  = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;

  // Shared multiplier: a signed 34-bit operand times a signed 18-bit operand.
  localparam int MulAW = 34;
  localparam int MulBW = 18;
  localparam int ProdW = MulAW + MulBW;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ALPHA  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WARMUP = 2'd2;

  // Configuration reset values.
  localparam logic [AlphaW-1:0]  ALPHA_RST  = 17'd6554;
  localparam logic [AlphaW-1:0]  ALPHA_ONE  = 17'd65536;
  localparam logic [GainW-1:0]   GAIN_RST   = 16'd512;
  localparam logic [WarmupW-1:0] WARMUP_RST = 16'd1;

  // Input action codes.
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MULA,
    ST_UPD,
    ST_MULT,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic diff;
    logic mula;
    logic upd;
    logic mult;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
  } sts_t;

  // Saturating increment of a 32-bit counter.
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    r = (v == '1) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

[rtl/core/atcd_ctrl.sv]
module atcd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_action,
  output logic          in_stall,
  input  atcd_pkg::sts_t sts,
  output atcd_pkg::cmd_t cmd
);
  import atcd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a clear goes straight to the result step.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_action == ACT_CLEAR) ? ST_FIN : ST_DIFF;
        end
      end
      ST_DIFF: state_nxt = ST_MULA;
      ST_MULA: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_MULT;
      ST_MULT: state_nxt = ST_FIN;
      ST_FIN: begin
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIFF: cmd.diff = 1'b1;
      ST_MULA: cmd.mula = 1'b1;
      ST_UPD:  cmd.upd  = 1'b1;
      ST_MULT: cmd.mult = 1'b1;
      ST_FIN:  cmd.fin  = sts.slot_free;
      default: cmd      = '0;
    endcase
  end

endmodule

[rtl/core/atcd_datapath.sv]
module atcd_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  atcd_pkg::cmd_t                    cmd,
  output atcd_pkg::sts_t                    sts,
  input  logic                              cfg_valid,
  input  logic [atcd_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [atcd_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                              in_action,
  input  logic signed [atcd_pkg::SampleW-1:0] in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [atcd_pkg::SampleW-1:0]      out_average_change,
  output logic [atcd_pkg::SampleW-1:0]      out_threshold,
  output logic                              out_above_flag,
  output logic                              out_below_flag,
  output logic                              out_above_event,
  output logic                              out_below_event,
  output logic [atcd_pkg::CountW-1:0]       out_above_count,
  output logic [atcd_pkg::CountW-1:0]       out_below_count,
  output logic [atcd_pkg::CountW-1:0]       out_sample_count
);
  import atcd_pkg::*;

  // Configuration registers.
  logic [AlphaW-1:0]  alpha_r;
  logic [GainW-1:0]   gain_r;
  logic [WarmupW-1:0] warmup_r;

  // Detector state.
  logic               seeded_r;
  logic [SampleW-1:0] prev_r;
  logic [SampleW-1:0] avg_r;
  logic               was_above_r;
  logic               was_below_r;
  logic [CountW-1:0]  above_cnt_r;
  logic [CountW-1:0]  below_cnt_r;
  logic [CountW-1:0]  sample_cnt_r;

  // Working registers for the item in progress.
  logic                      clear_r;
  logic [SampleW-1:0]        sample_r;
  logic [SampleW-1:0]        change_r;
  logic signed [SampleW:0]   diff_r;
  logic signed [ProdW-1:0]   prod_r;

  // Output register.
  logic               out_valid_r;
  logic [SampleW-1:0] o_avg_r;
  logic [SampleW-1:0] o_thr_r;
  logic               o_above_r;
  logic               o_below_r;
  logic               o_aev_r;
  logic               o_bev_r;
  logic [CountW-1:0]  o_acnt_r;
  logic [CountW-1:0]  o_bcnt_r;
  logic [CountW-1:0]  o_scnt_r;

  // Combinational terms.
  logic signed [SampleW:0]   delta;
  logic [SampleW-1:0]        delta_mag;
  logic [AlphaW-1:0]         alpha_eff;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [ProdW-1:0]   mul_p;
  logic signed [ProdW-1:0]   prod_sh;
  logic signed [SampleW+4:0] avg_sum;
  logic [SampleW-1:0]        avg_nxt;
  logic [SampleW-1:0]        thr_sat;
  logic signed [SampleW+1:0] s_ext;
  logic signed [SampleW+1:0] t_ext;
  logic                      warm;
  logic                      above_c;
  logic                      below_c;
  logic                      aev_c;
  logic                      bev_c;
  logic [CountW-1:0]         acnt_nxt;
  logic [CountW-1:0]         bcnt_nxt;
  logic [CountW-1:0]         scnt_nxt;
  logic                      was_above_nxt;
  logic                      was_below_nxt;

  assign sts.slot_free = !out_valid_r || !out_stall;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= ALPHA_RST;
      gain_r   <= GAIN_RST;
      warmup_r <= WARMUP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALPHA:  alpha_r  <= cfg_data;
        CFG_GAIN:   gain_r   <= cfg_data[GainW-1:0];
        CFG_WARMUP: warmup_r <= cfg_data[WarmupW-1:0];
        default:    ;
      endcase
    end
  end

  // Magnitude of the change from the previous sample. Before seeding the
  // previous sample is zero, so this is the magnitude of the sample itself.
  assign delta     = $signed({in_sample[SampleW-1], in_sample})
                   - $signed({prev_r[SampleW-1], prev_r});
  assign delta_mag = delta[SampleW] ? SampleW'(-delta) : SampleW'(delta);

  // An alpha above one counts as one.
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;

  // Shared multiplier: the smoothing product first, then the threshold.
  always_comb begin
    if (cmd.mult) begin
      mul_a = $signed({2'b00, avg_r});
      mul_b = $signed({2'b00, gain_r});
    end else begin
      mul_a = $signed({diff_r[SampleW], diff_r});
      mul_b = $signed({1'b0, alpha_eff});
    end
  end
  assign mul_p = mul_a * mul_b;

  // Average update: the arithmetic shift floors toward minus infinity.
  assign prod_sh = prod_r >>> 16;
  assign avg_sum = $signed({5'b00000, avg_r}) + $signed(prod_sh[SampleW+4:0]);
  always_comb begin
    if (avg_sum[SampleW+4]) begin
      avg_nxt = '0;
    end else if (|avg_sum[SampleW+3:SampleW]) begin
      avg_nxt = '1;
    end else begin
      avg_nxt = avg_sum[SampleW-1:0];
    end
  end

  // Threshold, crossing flags, events and counters.
  assign thr_sat = (|prod_r[ProdW-1:SampleW+8]) ? '1 : prod_r[SampleW+7:8];
  assign s_ext   = $signed({{2{sample_r[SampleW-1]}}, sample_r});
  assign t_ext   = $signed({2'b00, thr_sat});
  assign warm    = ({1'b0, sample_cnt_r} + 33'd1) >= {17'd0, warmup_r};

  always_comb begin
    above_c       = 1'b0;
    below_c       = 1'b0;
    aev_c         = 1'b0;
    bev_c         = 1'b0;
    acnt_nxt      = above_cnt_r;
    bcnt_nxt      = below_cnt_r;
    was_above_nxt = was_above_r;
    was_below_nxt = was_below_r;
    if (warm) begin
      above_c       = s_ext > t_ext;
      below_c       = s_ext < -t_ext;
      aev_c         = above_c && !was_above_r;
      bev_c         = below_c && !was_below_r;
      was_above_nxt = above_c;
      was_below_nxt = below_c;
      if (aev_c) begin
        acnt_nxt = sat_inc(above_cnt_r);
      end
      if (bev_c) begin
        bcnt_nxt = sat_inc(below_cnt_r);
      end
    end
  end
  assign scnt_nxt = sat_inc(sample_cnt_r);

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clear_r  <= in_action;
      sample_r <= in_sample;
      change_r <= delta_mag;
    end
    if (cmd.diff) begin
      diff_r <= $signed({1'b0, change_r}) - $signed({1'b0, avg_r});
    end
    if (cmd.mula || cmd.mult) begin
      prod_r <= mul_p;
    end
  end

  // Detector state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r     <= 1'b0;
      prev_r       <= '0;
      avg_r        <= '0;
      was_above_r  <= 1'b0;
      was_below_r  <= 1'b0;
      above_cnt_r  <= '0;
      below_cnt_r  <= '0;
      sample_cnt_r <= '0;
    end else if (cmd.upd) begin
      seeded_r <= 1'b1;
      prev_r   <= sample_r;
      avg_r    <= seeded_r ? avg_nxt : change_r;
    end else if (cmd.fin) begin
      if (clear_r == ACT_CLEAR) begin
        seeded_r     <= 1'b0;
        prev_r       <= '0;
        avg_r        <= '0;
        was_above_r  <= 1'b0;
        was_below_r  <= 1'b0;
        above_cnt_r  <= '0;
        below_cnt_r  <= '0;
        sample_cnt_r <= '0;
      end else begin
        was_above_r  <= was_above_nxt;
        was_below_r  <= was_below_nxt;
        above_cnt_r  <= acnt_nxt;
        below_cnt_r  <= bcnt_nxt;
        sample_cnt_r <= scnt_nxt;
      end
    end
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload; a clear gives an all-zero result.
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (clear_r == ACT_CLEAR) begin
        o_avg_r   <= '0;
        o_thr_r   <= '0;
        o_above_r <= 1'b0;
        o_below_r <= 1'b0;
        o_aev_r   <= 1'b0;
        o_bev_r   <= 1'b0;
        o_acnt_r  <= '0;
        o_bcnt_r  <= '0;
        o_scnt_r  <= '0;
      end else begin
        o_avg_r   <= avg_r;
        o_thr_r   <= thr_sat;
        o_above_r <= above_c;
        o_below_r <= below_c;
        o_aev_r   <= aev_c;
        o_bev_r   <= bev_c;
        o_acnt_r  <= acnt_nxt;
        o_bcnt_r  <= bcnt_nxt;
        o_scnt_r  <= scnt_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_average_change = o_avg_r;
  assign out_threshold      = o_thr_r;
  assign out_above_flag     = o_above_r;
  assign out_below_flag     = o_below_r;
  assign out_above_event    = o_aev_r;
  assign out_below_event    = o_bev_r;
  assign out_above_count    = o_acnt_r;
  assign out_below_count    = o_bcnt_r;
  assign out_sample_count   = o_scnt_r;

endmodule

[rtl/core/adaptive_threshold_crossing_detector.sv]
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall    action, sample
// out_      output     out_valid / out_stall  average, threshold, flags, events, counts
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A recorded sample steps through the DIFF, MULA, UPD, MULT and FIN states before
// its result is presented; the next input is taken once the sequencer is back in
// IDLE, and a clear goes straight from IDLE to FIN. The steps are set by the single
// shared multiplier, used first for the smoothing product and then for the
// threshold product.
// A finished result waits in the output register while the next sample is
// taken; that sample then holds in its last step until the register drains.
// Reset is synchronous and active low; configuration writes complete at once.
module adaptive_threshold_crossing_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic signed [atcd_pkg::SampleW-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [atcd_pkg::SampleW-1:0]        out_average_change,
  output logic [atcd_pkg::SampleW-1:0]        out_threshold,
  output logic                                out_above_flag,
  output logic                                out_below_flag,
  output logic                                out_above_event,
  output logic                                out_below_event,
  output logic [atcd_pkg::CountW-1:0]         out_above_count,
  output logic [atcd_pkg::CountW-1:0]         out_below_count,
  output logic [atcd_pkg::CountW-1:0]         out_sample_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [atcd_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [atcd_pkg::CfgDataW-1:0]       cfg_data
);
  import atcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Sequencer.
  atcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic, state and output register.
  atcd_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_action          (in_action),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_average_change (out_average_change),
    .out_threshold      (out_threshold),
    .out_above_flag     (out_above_flag),
    .out_below_flag     (out_below_flag),
    .out_above_event    (out_above_event),
    .out_below_event    (out_below_event),
    .out_above_count    (out_above_count),
    .out_below_count    (out_below_count),
    .out_sample_count   (out_sample_count)
  );

endmodule

[rtl/core/atcd_checker.sv]
module atcd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [atcd_pkg::SampleW-1:0] out_average_change,
  input logic                         out_above_flag,
  input logic                         out_below_flag,
  input logic                         out_above_event,
  input logic                         out_below_event
);
  import atcd_pkg::*;

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average_change))
    else $error("stalled result changed");

  // No result is pending straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The threshold is never negative, so the two flags exclude each other.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_above_flag && out_below_flag))
    else $error("above and below flagged together");

  // An above event, a rising edge of the above flag, comes only with that flag set.
  a_above_evt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_above_event |-> out_above_flag)
    else $error("above event without above flag");

  // A below event, a rising edge of the below flag, comes only with that flag set.
  a_below_evt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_below_event |-> out_below_flag)
    else $error("below event without below flag");

endmodule

bind adaptive_threshold_crossing_detector atcd_checker u_atcd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_average_change (out_average_change),
  .out_above_flag     (out_above_flag),
  .out_below_flag     (out_below_flag),
  .out_above_event    (out_above_event),
  .out_below_event    (out_below_event)
);
